### hdl/ssd_pkg.sv
// shared types, constants and segment table for the decimal scan driver
`default_nettype none
package ssd_pkg;

    localparam int DIGIT_COUNT = 3;
    localparam int OPCODE_W = 2;
    localparam int VALUE_W = 14;
    localparam int NUMBER_W = 10;
    localparam int CODE_W = 4;
    localparam int POINT_W = 2;
    localparam int SCAN_W = 2;
    localparam int DWELL_W = 8;
    localparam int SEG_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OPCODE_W-1:0] OP_LOAD_FIXED = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_INT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECIMAL_MODE = 2'd1;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 8'd5;

    localparam logic [POINT_W-1:0] POINT_HUNDREDTHS = 2'd0;
    localparam logic [POINT_W-1:0] POINT_TENTHS = 2'd1;
    localparam logic [POINT_W-1:0] NO_POINT = 2'd3;

    localparam logic [VALUE_W-1:0] FIXED_LIMIT = 14'd1000;
    localparam logic [VALUE_W-1:0] SHOW_MAX = 14'd999;

    // x / 10 == (x * 52429) >> 19 for every 14-bit x
    localparam int DIV10_MUL = 52429;
    localparam int DIV10_SHIFT = 19;
    localparam int TENTH_W = 11;
    // n / 100 == (n * 41) >> 12 for n up to 999
    localparam int DIV100_MUL = 41;
    localparam int DIV100_SHIFT = 12;
    // r / 10 == (r * 205) >> 11 for r up to 99
    localparam int DIV10S_MUL = 205;
    localparam int DIV10S_SHIFT = 11;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } item_word_t;

    typedef struct packed {
        logic [SEG_W-1:0]       segments;
        logic [DIGIT_COUNT-1:0] digit_select;
    } result_word_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [NUMBER_W-1:0] number;
        logic [POINT_W-1:0]  point;
    } number_word_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]                 opcode;
        logic [DIGIT_COUNT-1:0][CODE_W-1:0] digits;
        logic [POINT_W-1:0]                  point;
    } digit_word_t;

    // active-low a..g in bits 0..6, point off in bit 7
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] pattern;
        case (code)
            4'h0: pattern = 8'hc0;
            4'h1: pattern = 8'hf9;
            4'h2: pattern = 8'ha4;
            4'h3: pattern = 8'hb0;
            4'h4: pattern = 8'h99;
            4'h5: pattern = 8'h92;
            4'h6: pattern = 8'h82;
            4'h7: pattern = 8'hf8;
            4'h8: pattern = 8'h80;
            4'h9: pattern = 8'h90;
            4'ha: pattern = 8'h88;
            4'hb: pattern = 8'h83;
            4'hc: pattern = 8'hc6;
            4'hd: pattern = 8'ha1;
            4'he: pattern = 8'h86;
            4'hf: pattern = 8'h8e;
            default: pattern = 8'hff;
        endcase
        return pattern;
    endfunction

endpackage
`default_nettype wire

### hdl/ssd_scale.sv
// input register and scaling of the loaded value to a saturated 0..999 number
`default_nettype none
module ssd_scale (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                decimal_mode,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ssd_pkg::item_word_t in_word,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ssd_pkg::number_word_t    out_word
);

    logic                          hold_valid_reg;
    ssd_pkg::item_word_t           hold_reg;
    logic                          num_valid_reg;
    ssd_pkg::number_word_t         num_reg;
    logic                          advance;
    logic [29:0]                   prod;
    logic [ssd_pkg::TENTH_W-1:0]   tenth;
    logic [ssd_pkg::VALUE_W-1:0]   raw;
    ssd_pkg::number_word_t         num_next;

    assign advance = hold_valid_reg && (!num_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;
    assign out_valid = num_valid_reg;
    assign out_word = num_reg;

    assign prod = 30'(hold_reg.value) * 30'(ssd_pkg::DIV10_MUL);
    assign tenth = prod[ssd_pkg::DIV10_SHIFT +: ssd_pkg::TENTH_W];

    always_comb
    begin
        raw = hold_reg.value;
        num_next.opcode = hold_reg.opcode;
        num_next.point = ssd_pkg::NO_POINT;
        case (hold_reg.opcode)
            ssd_pkg::OP_LOAD_FIXED:
            begin
                if (hold_reg.value >= ssd_pkg::FIXED_LIMIT || decimal_mode)
                begin
                    raw = ssd_pkg::VALUE_W'(tenth);
                    num_next.point = ssd_pkg::POINT_TENTHS;
                end
                else
                begin
                    num_next.point = ssd_pkg::POINT_HUNDREDTHS;
                end
            end
            ssd_pkg::OP_LOAD_INT:
            begin
                num_next.point = ssd_pkg::NO_POINT;
            end
            default:
            begin
                num_next.point = ssd_pkg::NO_POINT;
            end
        endcase
        if (raw > ssd_pkg::SHOW_MAX)
        begin
            raw = ssd_pkg::SHOW_MAX;
        end
        num_next.number = raw[ssd_pkg::NUMBER_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            num_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                num_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                num_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg <= in_word;
        end
        if (advance)
        begin
            num_reg <= num_next;
        end
    end

endmodule
`default_nettype wire

### hdl/ssd_split.sv
// split a 0..999 number into hundreds, tens and ones digit codes
`default_nettype none
module ssd_split (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ssd_pkg::number_word_t in_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ssd_pkg::digit_word_t       out_word
);

    logic                         dig_valid_reg;
    ssd_pkg::digit_word_t         dig_reg;
    ssd_pkg::digit_word_t         dig_next;
    logic [15:0]                  p_hund;
    logic [ssd_pkg::CODE_W-1:0]   hund;
    logic [9:0]                   hund_scaled;
    logic [9:0]                   rem_wide;
    logic [6:0]                   rem;
    logic [14:0]                  p_tens;
    logic [ssd_pkg::CODE_W-1:0]   tens;
    logic [6:0]                   tens_scaled;
    logic [6:0]                   ones_wide;

    assign in_ready = !dig_valid_reg || out_ready;
    assign out_valid = dig_valid_reg;
    assign out_word = dig_reg;

    assign p_hund = 16'(in_word.number) * 16'(ssd_pkg::DIV100_MUL);
    assign hund = p_hund[ssd_pkg::DIV100_SHIFT +: ssd_pkg::CODE_W];
    assign hund_scaled = 10'(hund) * 10'(100);
    assign rem_wide = in_word.number - hund_scaled;
    assign rem = rem_wide[6:0];
    assign p_tens = 15'(rem) * 15'(ssd_pkg::DIV10S_MUL);
    assign tens = p_tens[ssd_pkg::DIV10S_SHIFT +: ssd_pkg::CODE_W];
    assign tens_scaled = 7'(tens) * 7'(10);
    assign ones_wide = rem - tens_scaled;

    always_comb
    begin
        dig_next.opcode = in_word.opcode;
        dig_next.point = in_word.point;
        dig_next.digits[0] = hund;
        dig_next.digits[1] = tens;
        dig_next.digits[2] = ones_wide[ssd_pkg::CODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            dig_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dig_reg <= dig_next;
        end
    end

endmodule
`default_nettype wire

### hdl/ssd_scan.sv
// display state, dwell counter, scan position and result register
`default_nettype none
module ssd_scan (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [ssd_pkg::DWELL_W-1:0] dwell_ticks,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire ssd_pkg::digit_word_t        in_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ssd_pkg::result_word_t            out_word,
    output logic [ssd_pkg::SCAN_W-1:0]       scan_digit
);

    logic [ssd_pkg::DIGIT_COUNT-1:0][ssd_pkg::CODE_W-1:0] digits_reg;
    logic [ssd_pkg::DIGIT_COUNT-1:0][ssd_pkg::CODE_W-1:0] digits_next;
    logic [ssd_pkg::POINT_W-1:0]  point_reg;
    logic [ssd_pkg::POINT_W-1:0]  point_next;
    logic [ssd_pkg::SCAN_W-1:0]   scan_reg;
    logic [ssd_pkg::SCAN_W-1:0]   scan_next;
    logic [ssd_pkg::DWELL_W-1:0]  dwell_reg;
    logic [ssd_pkg::DWELL_W-1:0]  dwell_next;
    logic [ssd_pkg::DWELL_W-1:0]  dwell_inc;
    logic                         res_valid_reg;
    ssd_pkg::result_word_t        res_reg;
    ssd_pkg::result_word_t        res_next;
    logic [ssd_pkg::CODE_W-1:0]   code;
    logic                         fire;

    assign in_ready = !res_valid_reg || out_ready;
    assign fire = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_word = res_reg;
    assign scan_digit = scan_reg;
    assign dwell_inc = dwell_reg + 8'd1;

    always_comb
    begin
        digits_next = digits_reg;
        point_next = point_reg;
        scan_next = scan_reg;
        dwell_next = dwell_reg;
        case (in_word.opcode)
            ssd_pkg::OP_LOAD_FIXED, ssd_pkg::OP_LOAD_INT:
            begin
                digits_next = in_word.digits;
                point_next = in_word.point;
            end
            ssd_pkg::OP_TICK:
            begin
                dwell_next = dwell_inc;
                if (dwell_inc == '0 || dwell_inc >= dwell_ticks)
                begin
                    dwell_next = '0;
                    if (scan_reg == ssd_pkg::SCAN_W'(ssd_pkg::DIGIT_COUNT - 1))
                    begin
                        scan_next = '0;
                    end
                    else
                    begin
                        scan_next = scan_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                dwell_next = dwell_reg;
            end
        endcase

        case (scan_next)
            2'd0:
            begin
                code = digits_next[0];
                res_next.digit_select = 3'b001;
            end
            2'd1:
            begin
                code = digits_next[1];
                res_next.digit_select = 3'b010;
            end
            2'd2:
            begin
                code = digits_next[2];
                res_next.digit_select = 3'b100;
            end
            default:
            begin
                code = digits_next[0];
                res_next.digit_select = 3'b001;
            end
        endcase
        res_next.segments = ssd_pkg::seg_pattern(code);
        if (point_next == scan_next)
        begin
            res_next.segments[ssd_pkg::SEG_W-1] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= '0;
            point_reg <= ssd_pkg::POINT_HUNDREDTHS;
            scan_reg <= '0;
            dwell_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                digits_reg <= digits_next;
                point_reg <= point_next;
                scan_reg <= scan_next;
                dwell_reg <= dwell_next;
            end
            if (in_ready)
            begin
                res_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

### hdl/seven_segment_decimal_scan_driver_unit.sv
// top level of the three-digit multiplexed seven-segment scan driver
//
// item channel (item_valid/item_ready/item) takes one word per cycle while it
// is ready: a load of a fixed-point value in hundredths, a load of an integer,
// or a scan tick. every accepted word gives exactly one result word on the
// result channel (result_valid/result_ready/result): the active-low segment
// pattern and the one-hot select of the digit being driven after that word's
// update. throughput is one word per cycle while the result receiver does
// not stall; words pass a four-register pipeline: input register, scaling,
// digit split, then display state and result register.
// each stage holds its word while the next one is full, and an empty stage
// takes a new word even when the result receiver stalls, so bubbles collapse.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; index 0
// sets the dwell ticks, index 1 the decimal mode; other indexes are ignored.
// users change configuration only with no word in flight; the block does not check.
// reset clears the pipeline, shows all zeros with the point on digit 0, scan on
// digit 0, dwell ticks 5 and two decimals.
`default_nettype none
module seven_segment_decimal_scan_driver_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire ssd_pkg::item_word_t             item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output ssd_pkg::result_word_t                result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ssd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [ssd_pkg::DWELL_W-1:0] dwell_ticks_reg;
    logic                        decimal_mode_reg;
    logic                        num_valid;
    logic                        num_ready;
    ssd_pkg::number_word_t       num_word;
    logic                        dig_valid;
    logic                        dig_ready;
    ssd_pkg::digit_word_t        dig_word;
    logic [ssd_pkg::SCAN_W-1:0]  scan_digit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg <= ssd_pkg::DWELL_RESET;
            decimal_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssd_pkg::CFG_DWELL_TICKS: dwell_ticks_reg <= cfg_data;
                ssd_pkg::CFG_DECIMAL_MODE: decimal_mode_reg <= cfg_data[0];
                default: decimal_mode_reg <= decimal_mode_reg;
            endcase
        end
    end

    ssd_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .decimal_mode (decimal_mode_reg),
        .in_valid     (item_valid),
        .in_ready     (item_ready),
        .in_word      (item),
        .out_valid    (num_valid),
        .out_ready    (num_ready),
        .out_word     (num_word)
    );

    ssd_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_word   (num_word),
        .out_valid (dig_valid),
        .out_ready (dig_ready),
        .out_word  (dig_word)
    );

    ssd_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .dwell_ticks (dwell_ticks_reg),
        .in_valid    (dig_valid),
        .in_ready    (dig_ready),
        .in_word     (dig_word),
        .out_valid   (result_valid),
        .out_ready   (result_ready),
        .out_word    (result),
        .scan_digit  (scan_digit)
    );

    // a shown result always drives exactly one digit
    a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot(result.digit_select))
        else $error("digit select not one-hot");

    // scan position never leaves the three digits
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_digit != 2'd3)
        else $error("scan position out of range");

    // with the result register empty the whole pipeline can move, so input is open
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input blocked while result register empty");

    // an accepted word with nothing else in flight moves through the pipeline to result_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && !num_valid && !dig_valid && !result_valid)
        |-> ##4 result_valid)
        else $error("result did not appear after three cycles");

endmodule
`default_nettype wire
